@@ rtl/acw_pkg.sv @@
package acw_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int OUT_W         = 24;
  localparam int Z_W           = 43;
  localparam int E_W           = 59;
  localparam int CNT_W         = 13;
  localparam int CNT_LIM       = 8191;
  localparam int BLOCK_MAX_DEF = 4096;
  localparam int STATE_W_DEF   = 24;
  localparam int COEF_W        = 16;
  localparam int FRAC_BITS     = 14;
  localparam int IN_SHIFT      = 5;
  localparam int NUM_STAGES    = 5;
  localparam int NUM_TAPS      = 5;
  localparam int LAST_A_STAGE  = 2;
  localparam int FIRST_C_STAGE = 3;
  localparam int NUM_SQ        = 3;
  localparam int IDX_W         = 3;
  localparam int SQ_W          = 2;

  typedef logic signed [COEF_W-1:0] coef_t;

  // per stage: b0, b1, b2, -a1, -a2 (feedback terms stored negated), Q2.14
  // stages 0..2 are the A cascade, stages 3..4 the C cascade
  localparam coef_t COEF [NUM_STAGES][NUM_TAPS] = '{
    '{ 16'sd4955,      16'sd0, -16'sd4955,  16'sd16368,  -16'sd6477},
    '{16'sd15512, -16'sd31025, 16'sd15512,  16'sd30964, -16'sd14701},
    '{16'sd16384, -16'sd10192,  16'sd1907, -16'sd10192,   16'sd1907},
    '{16'sd16148, -16'sd32296, 16'sd16148,  16'sd32313, -16'sd15935},
    '{ 16'sd1075,   16'sd2148,  16'sd1075,  16'sd19625,  -16'sd7538}
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_RND,
    S_SQ,
    S_OUT
  } state_t;

  typedef enum logic [SQ_W-1:0] {
    SQ_RAW,
    SQ_A,
    SQ_C
  } sq_sel_t;

  typedef struct packed {
    logic             load_in;
    logic             mul_en;
    logic             acc_clr;
    logic             acc_add;
    logic             rnd;
    logic             sq_mul;
    sq_sel_t          sq_sel;
    logic             sq_add;
    logic             tally_inc;
    logic             load_out;
    logic [IDX_W-1:0] stage;
    logic [IDX_W-1:0] tap;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_stat_t;

endpackage

@@ rtl/acw_ctrl.sv @@
module acw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  acw_pkg::dp_stat_t stat,
  output acw_pkg::dp_cmd_t  cmd
);

  acw_pkg::state_t               state, state_next;
  logic [acw_pkg::IDX_W-1:0]     tap, tap_next;
  logic [acw_pkg::IDX_W-1:0]     stage, stage_next;
  logic [acw_pkg::SQ_W-1:0]      sq, sq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acw_pkg::S_IDLE;
      tap   <= '0;
      stage <= '0;
      sq    <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      stage <= stage_next;
      sq    <= sq_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    stage_next = stage;
    sq_next    = sq;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.stage  = stage;
    cmd.tap    = tap;
    cmd.sq_sel = acw_pkg::SQ_RAW;
    unique case (state)
      acw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          tap_next    = '0;
          stage_next  = '0;
          state_next  = acw_pkg::S_MUL;
        end
      end
      acw_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        // first tap clears the accumulator, later taps add the previous product
        if (tap == '0) begin
          cmd.acc_clr = 1'b1;
        end else begin
          cmd.acc_add = 1'b1;
        end
        if (tap == acw_pkg::IDX_W'(acw_pkg::NUM_TAPS - 1)) begin
          state_next = acw_pkg::S_ACC;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      acw_pkg::S_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = acw_pkg::S_RND;
      end
      acw_pkg::S_RND: begin
        cmd.rnd  = 1'b1;
        tap_next = '0;
        if (stage == acw_pkg::IDX_W'(acw_pkg::NUM_STAGES - 1)) begin
          sq_next    = '0;
          state_next = acw_pkg::S_SQ;
        end else begin
          stage_next = stage + 1'b1;
          state_next = acw_pkg::S_MUL;
        end
      end
      acw_pkg::S_SQ: begin
        if (sq < acw_pkg::SQ_W'(acw_pkg::NUM_SQ)) begin
          cmd.sq_mul = 1'b1;
          cmd.sq_sel = acw_pkg::sq_sel_t'(sq);
        end
        if (sq != '0) begin
          cmd.sq_add = 1'b1;
        end
        if (sq == acw_pkg::SQ_W'(acw_pkg::NUM_SQ)) begin
          cmd.tally_inc = 1'b1;
          state_next    = acw_pkg::S_OUT;
        end else begin
          sq_next = sq + 1'b1;
        end
      end
      acw_pkg::S_OUT: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = acw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = acw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/acw_datapath.sv @@
module acw_datapath #(
  parameter int STATE_WIDTH = acw_pkg::STATE_W_DEF,
  parameter int BLOCK_MAX   = acw_pkg::BLOCK_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  acw_pkg::dp_cmd_t                    cmd,
  output acw_pkg::dp_stat_t                   stat,
  input  logic signed [acw_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [acw_pkg::OUT_W-1:0]    a_sample,
  output logic signed [acw_pkg::OUT_W-1:0]    c_sample,
  output logic                                block_done,
  output logic [acw_pkg::Z_W-1:0]             z_energy,
  output logic [acw_pkg::E_W-1:0]             a_energy,
  output logic [acw_pkg::E_W-1:0]             c_energy,
  output logic [acw_pkg::CNT_W-1:0]           block_count
);

  localparam int HW     = (STATE_WIDTH > acw_pkg::OUT_W) ? STATE_WIDTH : acw_pkg::OUT_W;
  localparam int PROD_W = HW + acw_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SQ_PW  = 2 * acw_pkg::OUT_W;
  localparam int NS     = acw_pkg::NUM_STAGES;
  localparam int CAP    = (BLOCK_MAX > acw_pkg::CNT_LIM) ? acw_pkg::CNT_LIM : BLOCK_MAX;
  localparam int OW     = acw_pkg::OUT_W;

  localparam logic signed [HW-1:0] Y_MAX =
    HW'((longint'(1) <<< (STATE_WIDTH - 1)) - longint'(1));
  localparam logic signed [HW-1:0] Y_MIN = -Y_MAX - HW'(1);

  function automatic logic [OW-1:0] sat_out(input logic [HW-1:0] v);
    logic hi_ok;
    hi_ok = (v[HW-1:OW-1] == {(HW-OW+1){v[HW-1]}});
    if (hi_ok) begin
      return v[OW-1:0];
    end else if (v[HW-1]) begin
      return {1'b1, {(OW-1){1'b0}}};
    end else begin
      return {1'b0, {(OW-1){1'b1}}};
    end
  endfunction

  // word registers
  logic signed [HW-1:0]                x_in;
  logic [acw_pkg::SAMPLE_W-1:0]        raw;
  logic                                last_q;

  // history ring, entry 0 always belongs to the stage being computed
  logic signed [HW-1:0]                x1 [NS];
  logic signed [HW-1:0]                x2 [NS];
  logic signed [HW-1:0]                y1 [NS];
  logic signed [HW-1:0]                y2 [NS];

  logic signed [HW-1:0]                y_cur;
  logic signed [HW-1:0]                a_y;
  logic signed [HW-1:0]                c_y;
  logic signed [PROD_W-1:0]            prod;
  logic signed [ACC_W-1:0]             acc;
  logic signed [SQ_PW-1:0]             sq_prod;
  acw_pkg::sq_sel_t                    sq_sel_q;

  logic [acw_pkg::Z_W-1:0]             z_sum;
  logic [acw_pkg::E_W-1:0]             a_sum;
  logic [acw_pkg::E_W-1:0]             c_sum;
  logic [acw_pkg::CNT_W-1:0]           tally;

  logic signed [HW-1:0]                stage_in;
  logic signed [HW-1:0]                mul_op;
  acw_pkg::coef_t                      coef_sel;
  logic signed [PROD_W-1:0]            mul_res;
  logic signed [ACC_W-1:0]             rnd_sum;
  logic signed [ACC_W-1:0]             rnd_shift;
  logic signed [HW-1:0]                y_new;
  logic [OW-1:0]                       a24;
  logic [OW-1:0]                       c24;
  logic signed [OW-1:0]                sq_op;
  logic signed [SQ_PW-1:0]             sq_res;
  logic [acw_pkg::Z_W:0]               z_add;
  logic [acw_pkg::E_W-1:0]             e_base;
  logic [acw_pkg::E_W:0]               e_add;

  // stage input: scaled sample for the first stage of each cascade
  assign stage_in = (cmd.stage == '0 ||
                     cmd.stage == acw_pkg::IDX_W'(acw_pkg::FIRST_C_STAGE)) ? x_in : y_cur;

  always_comb begin
    unique case (cmd.tap)
      3'd0:    mul_op = stage_in;
      3'd1:    mul_op = x1[0];
      3'd2:    mul_op = x2[0];
      3'd3:    mul_op = y1[0];
      3'd4:    mul_op = y2[0];
      default: mul_op = '0;
    endcase
  end

  assign coef_sel = acw_pkg::COEF[cmd.stage][cmd.tap];
  assign mul_res  = mul_op * coef_sel;

  // round half up then saturate to the state width
  assign rnd_sum   = acc + ACC_W'(1 << (acw_pkg::FRAC_BITS - 1));
  assign rnd_shift = rnd_sum >>> acw_pkg::FRAC_BITS;

  always_comb begin
    if (rnd_shift[ACC_W-1:STATE_WIDTH-1] ==
        {(ACC_W-STATE_WIDTH+1){rnd_shift[ACC_W-1]}}) begin
      y_new = HW'(signed'(rnd_shift[STATE_WIDTH-1:0]));
    end else if (rnd_shift[ACC_W-1]) begin
      y_new = Y_MIN;
    end else begin
      y_new = Y_MAX;
    end
  end

  assign a24 = sat_out(a_y);
  assign c24 = sat_out(c_y);

  always_comb begin
    unique case (cmd.sq_sel)
      acw_pkg::SQ_RAW: sq_op = {{(OW-acw_pkg::SAMPLE_W){raw[acw_pkg::SAMPLE_W-1]}}, raw};
      acw_pkg::SQ_A:   sq_op = a24;
      acw_pkg::SQ_C:   sq_op = c24;
      default:         sq_op = '0;
    endcase
  end

  assign sq_res = sq_op * sq_op;

  // squares are never negative, sums clip at all ones
  assign z_add  = {1'b0, z_sum} + {1'b0, sq_prod[acw_pkg::Z_W-1:0]};
  assign e_base = (sq_sel_q == acw_pkg::SQ_A) ? a_sum : c_sum;
  assign e_add  = {1'b0, e_base} +
                  {{(acw_pkg::E_W+2-SQ_PW){1'b0}}, sq_prod[SQ_PW-2:0]};

  assign stat.slot_free = !out_valid || out_ready;

  // payload and pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in   <= HW'(signed'({sample, {acw_pkg::IN_SHIFT{1'b0}}}));
      raw    <= sample;
      last_q <= last;
    end
    if (cmd.mul_en) begin
      prod <= mul_res;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.rnd) begin
      y_cur <= y_new;
      if (cmd.stage == acw_pkg::IDX_W'(acw_pkg::LAST_A_STAGE)) begin
        a_y <= y_new;
      end
      if (cmd.stage == acw_pkg::IDX_W'(NS - 1)) begin
        c_y <= y_new;
      end
    end
    if (cmd.sq_mul) begin
      sq_prod  <= sq_res;
      sq_sel_q <= cmd.sq_sel;
    end
    if (cmd.load_out) begin
      a_sample   <= a24;
      c_sample   <= c24;
      block_done <= last_q;
      if (last_q) begin
        z_energy    <= z_sum;
        a_energy    <= a_sum;
        c_energy    <= c_sum;
        block_count <= tally;
      end else begin
        z_energy    <= '0;
        a_energy    <= '0;
        c_energy    <= '0;
        block_count <= '0;
      end
    end
  end

  // filter histories, rotated one stage per round step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        x1[i] <= '0;
        x2[i] <= '0;
        y1[i] <= '0;
        y2[i] <= '0;
      end
    end else if (cmd.rnd) begin
      for (int i = 0; i < NS - 1; i++) begin
        x1[i] <= x1[i+1];
        x2[i] <= x2[i+1];
        y1[i] <= y1[i+1];
        y2[i] <= y2[i+1];
      end
      x1[NS-1] <= stage_in;
      x2[NS-1] <= x1[0];
      y1[NS-1] <= y_new;
      y2[NS-1] <= y1[0];
    end
  end

  // accumulators, count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      z_sum     <= '0;
      a_sum     <= '0;
      c_sum     <= '0;
      tally     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sq_add) begin
        unique case (sq_sel_q)
          acw_pkg::SQ_RAW: z_sum <= z_add[acw_pkg::Z_W] ? '1 : z_add[acw_pkg::Z_W-1:0];
          acw_pkg::SQ_A:   a_sum <= e_add[acw_pkg::E_W] ? '1 : e_add[acw_pkg::E_W-1:0];
          acw_pkg::SQ_C:   c_sum <= e_add[acw_pkg::E_W] ? '1 : e_add[acw_pkg::E_W-1:0];
          default:         z_sum <= z_sum;
        endcase
      end
      if (cmd.tally_inc && tally < acw_pkg::CNT_W'(CAP)) begin
        tally <= tally + 1'b1;
      end
      if (cmd.load_out && last_q) begin
        z_sum <= '0;
        a_sum <= '0;
        c_sum <= '0;
        tally <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/a_c_weighting_energy_filter_unit.sv @@
// a/c weighting filter with block energy: each input word is a q1.15
// microphone sample; it is scaled to q4.20 and run through a three-stage
// a-weighting and a two-stage c-weighting direct-form-i biquad cascade
// (q2.14 coefficients, round half up, saturating q4.20 state). every word
// gives one output word with both weighted samples, saturated to 24 bits.
// the block also sums the squares of the raw, a and c samples and counts
// samples; on a word marked last the output carries those sums and the count
// (block_done high) and the sums and count clear, otherwise they read zero.
// the filter histories run on across blocks. all five biquad stages share a
// single multiply-accumulate unit that takes one tap per cycle; each stage
// steps through five taps, one accumulator drain and one round and saturate
// step. after the five stages the raw, a and c squares run through the
// shared squaring multiplier, and then the output register is loaded. no new
// word is taken before that load; the block is ready for the next word the
// cycle after the output register is loaded, while the result may still wait
// for out_ready. STATE_WIDTH sets the internal state width, BLOCK_MAX the
// count limit (capped at 8191).
module a_c_weighting_energy_filter_unit #(
  parameter int STATE_WIDTH = acw_pkg::STATE_W_DEF,
  parameter int BLOCK_MAX   = acw_pkg::BLOCK_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input word
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [acw_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  // output word
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [acw_pkg::OUT_W-1:0]    a_sample,
  output logic signed [acw_pkg::OUT_W-1:0]    c_sample,
  output logic                                block_done,
  output logic [acw_pkg::Z_W-1:0]             z_energy,
  output logic [acw_pkg::E_W-1:0]             a_energy,
  output logic [acw_pkg::E_W-1:0]             c_energy,
  output logic [acw_pkg::CNT_W-1:0]           block_count
);

  // command and status between sequencer and datapath
  acw_pkg::dp_cmd_t  cmd;
  acw_pkg::dp_stat_t stat;

  // sequencer: walks stages and taps, then the squares, then the output load
  acw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: history ring, shared mac, squarer, accumulators, output register
  acw_datapath #(
    .STATE_WIDTH (STATE_WIDTH),
    .BLOCK_MAX   (BLOCK_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sample      (sample),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .a_sample    (a_sample),
    .c_sample    (c_sample),
    .block_done  (block_done),
    .z_energy    (z_energy),
    .a_energy    (a_energy),
    .c_energy    (c_energy),
    .block_count (block_count)
  );

endmodule
